@@ rtl/bfbp_pkg.sv @@
// Shared types and constants for the best-fit block pool.
`default_nettype none

package bfbp_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int SIZE_BITS_DEF = 32;

	localparam int HANDLE_W   = 4;
	localparam int REQ_W      = 32;
	localparam int BSIZE_W    = 32;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [STATUS_W-1:0] {
		ST_REUSED  = 3'd0,
		ST_NEW     = 3'd1,
		ST_NOROOM  = 3'd2,
		ST_FREED   = 3'd3,
		ST_BADFREE = 3'd4
	} res_status_t;

	typedef struct packed {
		logic start;
		logic scan_en;
		logic shift_en;
		logic do_free;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_end;
		logic full;
		logic shift_done;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/bfbp_dp.sv @@
// Datapath: size-order and size memories, busy bits, scan pipeline, shifter, output register.
`default_nettype none

module bfbp_dp #(
	parameter int SLOTS     = bfbp_pkg::SLOTS_DEF,
	parameter int SIZE_BITS = bfbp_pkg::SIZE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bfbp_pkg::dp_cmd_t               cmd,
	output bfbp_pkg::dp_sts_t                    sts,
	input  wire logic [bfbp_pkg::REQ_W-1:0]      req_in,
	input  wire logic [bfbp_pkg::HANDLE_W-1:0]   fh_in,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [bfbp_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [bfbp_pkg::STATUS_W-1:0]        m_tuser
);
	import bfbp_pkg::*;

	localparam int HW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [SIZE_BITS-1:0] size_mem [SLOTS];
	logic [HW-1:0]        ord_mem  [SLOTS];

	logic [CW-1:0]        used_q;
	logic [SLOTS-1:0]     busy_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [HANDLE_W-1:0]  fh_q;
	logic [CW-1:0]        issue_q;
	logic                 v_s1, v_s2;
	logic [CW-1:0]        p_s1, p_s2;
	logic [HW-1:0]        h_s1, h_s2;
	logic [SIZE_BITS-1:0] sz_s2;
	logic                 busy_s2;
	logic [CW-1:0]        ins_q;
	logic                 found_q;
	logic [CW-1:0]        sp_q;
	logic                 wv_s1;
	logic [HW-1:0]        wa_s1;

	logic [HANDLE_W-1:0]  res_handle_q;
	logic [BSIZE_W-1:0]   res_size_q;
	res_status_t          res_status_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]  m_tuser_q;

	logic [SIZE_BITS+REQ_W-1:0]  req_ext;
	logic [SIZE_BITS-1:0]        req_w;
	logic                        fit, hit_now, last_now;
	logic                        issue, shift_rd, commit;
	logic [CW-1:0]               sp_m1;
	logic [HW-1:0]               ord_ra, ord_wa, ord_wd;
	logic                        ord_we;
	logic [HW-1:0]               new_h;
	logic [HW+HANDLE_W-1:0]      fh_ext;
	logic [HW-1:0]               fh_idx;
	logic                        fh_ok;
	logic [HW+HANDLE_W-1:0]      h2_ext, new_ext;
	logic [SIZE_BITS+BSIZE_W-1:0] sz_ext, req_oext;

	assign req_ext  = {{SIZE_BITS{1'b0}}, req_in};
	assign req_w    = req_ext[SIZE_BITS-1:0];

	assign fit      = sz_s2 >= req_q;
	assign hit_now  = v_s2 && fit && !busy_s2;
	assign last_now = v_s2 && ((p_s2 + CW'(1)) == used_q);

	assign sts.hit        = hit_now;
	assign sts.scan_end   = (used_q == '0) || (last_now && !hit_now);
	assign sts.full       = used_q == CW'(SLOTS);
	assign sts.shift_done = (sp_q == ins_q) && !wv_s1;
	assign sts.out_free   = !m_tvalid_q || m_tready;

	assign issue    = cmd.scan_en && (issue_q < used_q);
	assign shift_rd = cmd.shift_en && (sp_q > ins_q);
	assign commit   = cmd.shift_en && sts.shift_done;
	assign sp_m1    = sp_q - CW'(1);
	assign new_h    = used_q[HW-1:0];

	assign ord_ra = cmd.shift_en ? sp_m1[HW-1:0] : issue_q[HW-1:0];
	assign ord_we = wv_s1 || commit;
	assign ord_wa = commit ? ins_q[HW-1:0] : wa_s1;
	assign ord_wd = commit ? new_h : h_s1;

	assign fh_ext = {{HW{1'b0}}, fh_q};
	assign fh_idx = fh_ext[HW-1:0];
	assign fh_ok  = ({{CW{1'b0}}, fh_q} < {{HANDLE_W{1'b0}}, used_q}) && busy_q[fh_idx];

	assign h2_ext   = {{HANDLE_W{1'b0}}, h_s2};
	assign new_ext  = {{HANDLE_W{1'b0}}, new_h};
	assign sz_ext   = {{BSIZE_W{1'b0}}, sz_s2};
	assign req_oext = {{BSIZE_W{1'b0}}, req_q};

	always_ff @(posedge clk) begin
		if (ord_we)
			ord_mem[ord_wa] <= ord_wd;
		h_s1 <= ord_mem[ord_ra];
	end

	always_ff @(posedge clk) begin
		if (commit)
			size_mem[new_h] <= req_q;
		sz_s2 <= size_mem[h_s1];
	end

	always_ff @(posedge clk) begin
		p_s1    <= issue_q;
		p_s2    <= p_s1;
		h_s2    <= h_s1;
		busy_s2 <= busy_q[h_s1];
		wa_s1   <= sp_q[HW-1:0];
		if (cmd.start) begin
			req_q <= req_w;
			fh_q  <= fh_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			busy_q       <= '0;
			issue_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			ins_q        <= '0;
			found_q      <= 1'b0;
			sp_q         <= '0;
			wv_s1        <= 1'b0;
			res_handle_q <= '0;
			res_size_q   <= '0;
			res_status_q <= ST_REUSED;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			if (cmd.start) begin
				issue_q <= '0;
				v_s1    <= 1'b0;
				v_s2    <= 1'b0;
				ins_q   <= used_q;
				found_q <= 1'b0;
				sp_q    <= used_q;
				wv_s1   <= 1'b0;
			end else begin
				v_s1  <= issue;
				v_s2  <= v_s1;
				wv_s1 <= shift_rd;
				if (issue)
					issue_q <= issue_q + CW'(1);
				if (shift_rd)
					sp_q <= sp_m1;
				if (cmd.scan_en && v_s2 && fit && !found_q) begin
					ins_q   <= p_s2;
					found_q <= 1'b1;
				end
			end

			if (cmd.scan_en && hit_now) begin
				busy_q[h_s2] <= 1'b1;
				res_handle_q <= h2_ext[HANDLE_W-1:0];
				res_size_q   <= sz_ext[BSIZE_W-1:0];
				res_status_q <= ST_REUSED;
			end else if (cmd.scan_en && sts.scan_end && sts.full) begin
				res_handle_q <= '0;
				res_size_q   <= '0;
				res_status_q <= ST_NOROOM;
			end

			if (commit) begin
				busy_q[new_h] <= 1'b1;
				used_q        <= used_q + CW'(1);
				res_handle_q  <= new_ext[HANDLE_W-1:0];
				res_size_q    <= req_oext[BSIZE_W-1:0];
				res_status_q  <= ST_NEW;
			end

			if (cmd.do_free) begin
				if (fh_ok)
					busy_q[fh_idx] <= 1'b0;
				res_handle_q <= fh_q;
				res_size_q   <= '0;
				res_status_q <= fh_ok ? ST_FREED : ST_BADFREE;
			end

			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {{(OUT_DATA_W-BSIZE_W-HANDLE_W){1'b0}}, res_size_q, res_handle_q};
				m_tuser_q  <= res_status_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

@@ rtl/bfbp_ctrl.sv @@
// Controller: sequences scan, insert shift, free and result hand-off.
`default_nettype none

module bfbp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic              op,
	output bfbp_pkg::dp_cmd_t      cmd,
	input  wire bfbp_pkg::dp_sts_t sts
);
	import bfbp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FREE,
		S_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= op ? S_FREE : S_SCAN;
				end
				S_SCAN: begin
					if (sts.hit)
						state_q <= S_FINISH;
					else if (sts.scan_end)
						state_q <= sts.full ? S_FINISH : S_SHIFT;
				end
				S_SHIFT: begin
					if (sts.shift_done)
						state_q <= S_FINISH;
				end
				S_FREE: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready     = state_q == S_IDLE;
	assign cmd.start    = (state_q == S_IDLE) && s_tvalid;
	assign cmd.scan_en  = state_q == S_SCAN;
	assign cmd.shift_en = state_q == S_SHIFT;
	assign cmd.do_free  = state_q == S_FREE;
	assign cmd.out_load = (state_q == S_FINISH) && sts.out_free;

endmodule

`default_nettype wire

@@ rtl/best_fit_block_pool.sv @@
// Top level of the best-fit block pool: controller plus datapath.
// Free: the free state checks the handle and clears its busy mark; the finish state loads the result word.
// Allocate: scans the N blocks (one order-memory read per cycle, two-stage read pipeline),
// plus one-entry-per-cycle order-memory shifting when a block is created.
// One word in flight; a finished result may wait in the output register
// while the next word is taken.
// Reset (arst_n low) empties the table and clears all busy marks; no clearing pass.
`default_nettype none

module best_fit_block_pool #(
	parameter int SLOTS     = bfbp_pkg::SLOTS_DEF,
	parameter int SIZE_BITS = bfbp_pkg::SIZE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [bfbp_pkg::IN_DATA_W-1:0]    s_tdata,  // request_size, free_handle
	input  wire logic [0:0]                        s_tuser,  // opcode
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [bfbp_pkg::OUT_DATA_W-1:0]        m_tdata,  // result_handle, block_size
	output logic [bfbp_pkg::STATUS_W-1:0]          m_tuser   // result_status
);
	import bfbp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bfbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser[0]),
		.cmd      (cmd),
		.sts      (sts)
	);

	bfbp_dp #(
		.SLOTS     (SLOTS),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_in   (s_tdata[REQ_W-1:0]),
		.fh_in    (s_tdata[REQ_W+HANDLE_W-1:REQ_W]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
